@@ sv/ivs_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the indexed vector store
// used by the controller, the datapath and the top level; depends on nothing

package ivs_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int DATA_W   = 32;

    localparam logic [2:0] OP_READ   = 3'd0;
    localparam logic [2:0] OP_WRITE  = 3'd1;
    localparam logic [2:0] OP_INSERT = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_APPEND = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic signed [DATA_W-1:0] DATA_NONE = -32'sd1;

    typedef struct packed {
        logic [2:0]               func;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [1:0]               status;
        logic [6:0]               count;
        logic                     is_empty;
    } rsp_t;

    typedef enum logic [2:0] {
        A_POS,
        A_CNT,
        A_PTR,
        A_PTR_DN,
        A_PTR_UP
    } addr_sel_t;

    typedef enum logic {
        W_VAL,
        W_RAM
    } wdat_sel_t;

    typedef enum logic [1:0] {
        D_NONE,
        D_RAM,
        D_HELD
    } dsel_t;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        addr_sel_t  rd_sel;
        logic       wr_en;
        addr_sel_t  wr_sel;
        wdat_sel_t  wd_sel;
        logic       ptr_load;
        logic       ptr_from_cnt;
        logic       ptr_dec;
        logic       ptr_inc;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       hold_data;
        logic       emit;
        logic [1:0] emit_status;
        dsel_t      emit_dsel;
    } cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       idx_ok;
        logic       ins_ok;
        logic       full;
        logic       ptr_gt_pos;
        logic       ptr_next_lt_cnt;
        logic       out_free;
    } stat_t;

endpackage

@@ sv/ivs_ram.sv @@
`timescale 1ns / 1ps
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies

module ivs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/ivs_ctrl.sv @@
`timescale 1ns / 1ps
// sequencer for the indexed vector store: decodes each transaction and steps
// the datapath through reads, writes and element shifts; uses ivs_pkg

module ivs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ivs_pkg::stat_t stat,
    output ivs_pkg::cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_EXEC    = 10'b00_0000_0010,
        S_READ    = 10'b00_0000_0100,
        S_DONE    = 10'b00_0000_1000,
        S_INS_RD  = 10'b00_0001_0000,
        S_INS_WR  = 10'b00_0010_0000,
        S_REM_CAP = 10'b00_0100_0000,
        S_REM_RD  = 10'b00_1000_0000,
        S_REM_WR  = 10'b01_0000_0000,
        S_REM_OUT = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.func)
                    ivs_pkg::OP_READ:
                    begin
                        if (stat.idx_ok)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = ivs_pkg::A_POS;
                            state_next = S_READ;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ivs_pkg::ST_RANGE;
                            state_next      = S_IDLE;
                        end
                    end
                    ivs_pkg::OP_WRITE:
                    begin
                        if (stat.idx_ok)
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = ivs_pkg::A_POS;
                            cmd.wd_sel = ivs_pkg::W_VAL;
                            state_next = S_DONE;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ivs_pkg::ST_RANGE;
                            state_next      = S_IDLE;
                        end
                    end
                    ivs_pkg::OP_INSERT:
                    begin
                        if (!stat.ins_ok || stat.full)
                        begin
                            if (stat.out_free)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = stat.ins_ok ? ivs_pkg::ST_FULL
                                                              : ivs_pkg::ST_RANGE;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.ptr_load     = 1'b1;
                            cmd.ptr_from_cnt = 1'b1;
                            state_next       = S_INS_RD;
                        end
                    end
                    ivs_pkg::OP_REMOVE:
                    begin
                        if (stat.idx_ok)
                        begin
                            cmd.rd_en    = 1'b1;
                            cmd.rd_sel   = ivs_pkg::A_POS;
                            cmd.ptr_load = 1'b1;
                            state_next   = S_REM_CAP;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ivs_pkg::ST_RANGE;
                            state_next      = S_IDLE;
                        end
                    end
                    ivs_pkg::OP_APPEND:
                    begin
                        if (!stat.full)
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = ivs_pkg::A_CNT;
                            cmd.wd_sel  = ivs_pkg::W_VAL;
                            cmd.cnt_inc = 1'b1;
                            state_next  = S_DONE;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ivs_pkg::ST_FULL;
                            state_next      = S_IDLE;
                        end
                    end
                    default:
                    begin
                        // unused function codes leave the store alone
                        if (stat.out_free)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ivs_pkg::ST_OK;
                            state_next      = S_IDLE;
                        end
                    end
                endcase
            end
            S_READ:
            begin
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ivs_pkg::ST_OK;
                    cmd.emit_dsel   = ivs_pkg::D_RAM;
                    state_next      = S_IDLE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ivs_pkg::ST_OK;
                    state_next      = S_IDLE;
                end
            end
            S_INS_RD:
            begin
                // walk down from the top, then drop the new value into the gap
                if (stat.ptr_gt_pos)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ivs_pkg::A_PTR_DN;
                    state_next = S_INS_WR;
                end
                else
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = ivs_pkg::A_POS;
                    cmd.wd_sel  = ivs_pkg::W_VAL;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_INS_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = ivs_pkg::A_PTR;
                cmd.wd_sel  = ivs_pkg::W_RAM;
                cmd.ptr_dec = 1'b1;
                state_next  = S_INS_RD;
            end
            S_REM_CAP:
            begin
                cmd.hold_data = 1'b1;
                state_next    = S_REM_RD;
            end
            S_REM_RD:
            begin
                if (stat.ptr_next_lt_cnt)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ivs_pkg::A_PTR_UP;
                    state_next = S_REM_WR;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_REM_OUT;
                end
            end
            S_REM_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = ivs_pkg::A_PTR;
                cmd.wd_sel  = ivs_pkg::W_RAM;
                cmd.ptr_inc = 1'b1;
                state_next  = S_REM_RD;
            end
            S_REM_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ivs_pkg::ST_OK;
                    cmd.emit_dsel   = ivs_pkg::D_HELD;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == S_EXEC))
        else $error("accepted transaction did not enter decode");

    a_ins_shift_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_WR) |-> ($past(state_reg) == S_INS_RD))
        else $error("insert shift write without a preceding read");

    a_emit_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (state_reg == S_IDLE))
        else $error("result issued but sequencer did not return to idle");

endmodule

@@ sv/ivs_dpath.sv @@
`timescale 1ns / 1ps
// datapath for the indexed vector store: element ram, count, shift pointer
// and the result register; uses ivs_pkg and ivs_ram

module ivs_dpath (
    input  logic           clk,
    input  logic           rst_n,
    input  ivs_pkg::req_t  req,
    input  ivs_pkg::cmd_t  cmd,
    output ivs_pkg::stat_t stat,
    output ivs_pkg::rsp_t  rsp,
    output logic           rsp_valid,
    input  logic           rsp_stall
);

    logic [2:0]                       op_reg;
    logic [ivs_pkg::POS_W-1:0]        pos_reg;
    logic signed [ivs_pkg::DATA_W-1:0] val_reg;
    logic signed [ivs_pkg::DATA_W-1:0] data_reg;
    logic [ivs_pkg::CNT_W-1:0]        cnt_reg;
    logic [ivs_pkg::CNT_W-1:0]        cnt_next;
    logic [ivs_pkg::ADDR_W-1:0]       ptr_reg;
    logic [ivs_pkg::ADDR_W-1:0]       ptr_next;
    ivs_pkg::rsp_t                    rsp_reg;
    ivs_pkg::rsp_t                    rsp_next;
    logic                             rsp_valid_reg;
    logic                             rsp_valid_next;

    logic [ivs_pkg::CMP_W-1:0]        pos_ext;
    logic [ivs_pkg::CMP_W-1:0]        cnt_ext;
    logic [ivs_pkg::CMP_W-1:0]        ptr_ext;
    logic [ivs_pkg::ADDR_W-1:0]       pos_addr;
    logic [ivs_pkg::ADDR_W-1:0]       cnt_addr;
    logic [ivs_pkg::ADDR_W-1:0]       ptr_dn;
    logic [ivs_pkg::ADDR_W-1:0]       ptr_up;
    logic [ivs_pkg::ADDR_W-1:0]       rd_addr;
    logic [ivs_pkg::ADDR_W-1:0]       wr_addr;
    logic [ivs_pkg::DATA_W-1:0]       wr_data;
    logic [ivs_pkg::DATA_W-1:0]       rd_data;
    logic                             out_free;

    assign pos_ext  = ivs_pkg::CMP_W'(pos_reg);
    assign cnt_ext  = ivs_pkg::CMP_W'(cnt_reg);
    assign ptr_ext  = ivs_pkg::CMP_W'(ptr_reg);
    assign pos_addr = ivs_pkg::ADDR_W'(pos_ext);
    assign cnt_addr = ivs_pkg::ADDR_W'(cnt_reg);
    assign ptr_dn   = ptr_reg - ivs_pkg::ADDR_W'(1);
    assign ptr_up   = ptr_reg + ivs_pkg::ADDR_W'(1);
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        stat.func            = op_reg;
        stat.idx_ok          = (pos_ext < cnt_ext);
        stat.ins_ok          = (pos_ext <= cnt_ext);
        stat.full            = (cnt_reg == ivs_pkg::CNT_W'(ivs_pkg::CAPACITY));
        stat.ptr_gt_pos      = (ptr_ext > pos_ext);
        stat.ptr_next_lt_cnt = ((ptr_ext + ivs_pkg::CMP_W'(1)) < cnt_ext);
        stat.out_free        = out_free;
    end

    always_comb
    begin
        case (cmd.rd_sel)
            ivs_pkg::A_POS:    rd_addr = pos_addr;
            ivs_pkg::A_CNT:    rd_addr = cnt_addr;
            ivs_pkg::A_PTR:    rd_addr = ptr_reg;
            ivs_pkg::A_PTR_DN: rd_addr = ptr_dn;
            ivs_pkg::A_PTR_UP: rd_addr = ptr_up;
            default:           rd_addr = pos_addr;
        endcase
        case (cmd.wr_sel)
            ivs_pkg::A_POS:    wr_addr = pos_addr;
            ivs_pkg::A_CNT:    wr_addr = cnt_addr;
            ivs_pkg::A_PTR:    wr_addr = ptr_reg;
            ivs_pkg::A_PTR_DN: wr_addr = ptr_dn;
            ivs_pkg::A_PTR_UP: wr_addr = ptr_up;
            default:           wr_addr = pos_addr;
        endcase
        wr_data = (cmd.wd_sel == ivs_pkg::W_RAM) ? rd_data : val_reg;
    end

    ivs_ram #(
        .WIDTH (ivs_pkg::DATA_W),
        .DEPTH (ivs_pkg::CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + ivs_pkg::CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - ivs_pkg::CNT_W'(1);
        end

        ptr_next = ptr_reg;
        if (cmd.ptr_load)
        begin
            ptr_next = cmd.ptr_from_cnt ? cnt_addr : pos_addr;
        end
        else if (cmd.ptr_dec)
        begin
            ptr_next = ptr_dn;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_up;
        end

        // count in the result is the value after this transaction
        rsp_next          = rsp_reg;
        rsp_next.status   = cmd.emit_status;
        rsp_next.count    = 7'(cnt_reg);
        rsp_next.is_empty = (cnt_reg == '0);
        case (cmd.emit_dsel)
            ivs_pkg::D_RAM:  rsp_next.data = rd_data;
            ivs_pkg::D_HELD: rsp_next.data = data_reg;
            default:         rsp_next.data = ivs_pkg::DATA_NONE;
        endcase
        if (!cmd.emit)
        begin
            rsp_next = rsp_reg;
        end

        rsp_valid_next = rsp_valid_reg;
        if (cmd.emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        rsp_reg <= rsp_next;
        if (cmd.load)
        begin
            op_reg  <= req.func;
            pos_reg <= req.position;
            val_reg <= req.value;
        end
        if (cmd.hold_data)
        begin
            data_reg <= rd_data;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.rd_en && cmd.wr_en))
        else $error("ram read and write issued in the same cycle");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_ext <= ivs_pkg::CMP_W'(ivs_pkg::CAPACITY))
        else $error("element count above capacity");

    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result overwrote a pending transaction");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cnt_inc || cmd.cnt_dec) |=> (cnt_reg != $past(cnt_reg)))
        else $error("count update lost");

endmodule

@@ sv/indexed_vector_store.sv @@
`timescale 1ns / 1ps
// Indexed vector store: an ordered list of up to CAPACITY signed 32-bit values
// held in a single-port-per-direction ram, with read, overwrite, insert,
// remove and append; each request transaction gives exactly one response
// transaction carrying data, status, count and an empty flag. One request is
// handled at a time. Shifts move one element at a time, a read followed by a
// write, through the ram's read and write ports. A stalled response holds
// the block. No clearing pass is needed after reset.
// depends on ivs_pkg, ivs_ctrl, ivs_dpath and ivs_ram

module indexed_vector_store (
    input  logic          clk,
    input  logic          rst_n,
    input  ivs_pkg::req_t req,
    input  logic          req_valid,
    output logic          req_stall,
    output ivs_pkg::rsp_t rsp,
    output logic          rsp_valid,
    input  logic          rsp_stall
);

    ivs_pkg::cmd_t  cmd;
    ivs_pkg::stat_t stat;

    ivs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ivs_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

endmodule

@@ tb/ivs_checker.sv @@
`timescale 1ns / 1ps
// transaction checker for the indexed vector store: keeps its own copy of the list,
// predicts one response per accepted request and compares them in order
// depends on ivs_pkg

module ivs_checker
    import ivs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  logic req_valid,
    input  logic req_stall,
    input  rsp_t rsp,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  logic final_check,
    output int   errors,
    output int   pending
);

    logic signed [DATA_W-1:0] cells [CAPACITY];
    int                       n_elems;
    rsp_t                     expected_rsp [$];
    rsp_t                     want;

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    // applies one operation to the shadow list and builds its response
    task automatic apply_list_op(input req_t r, output rsp_t res);
        int p;
        int k;
        p          = r.position;
        res.data   = DATA_NONE;
        res.status = ST_OK;
        case (r.func)
            OP_READ:
                if (p >= n_elems)
                    res.status = ST_RANGE;
                else
                    res.data = cells[p];
            OP_WRITE:
                if (p >= n_elems)
                    res.status = ST_RANGE;
                else
                    cells[p] = r.value;
            OP_INSERT:
                // range check wins over the full check
                if (p > n_elems)
                    res.status = ST_RANGE;
                else if (n_elems >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    for (k = n_elems; k > p; k--)
                        cells[k] = cells[k - 1];
                    cells[p] = r.value;
                    n_elems++;
                end
            OP_REMOVE:
                if (p >= n_elems)
                    res.status = ST_RANGE;
                else
                begin
                    res.data = cells[p];
                    for (k = p; k + 1 < n_elems; k++)
                        cells[k] = cells[k + 1];
                    n_elems--;
                end
            OP_APPEND:
                if (n_elems >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    cells[n_elems] = r.value;
                    n_elems++;
                end
            default:
                ;
        endcase
        res.count    = n_elems[6:0];
        res.is_empty = (n_elems == 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_elems = 0;
            expected_rsp.delete();
            pending = 0;
        end
        else
        begin
            // response first, so a spurious one cannot match this cycle's request
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                    report_mismatch("response transaction with nothing expected");
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.data !== want.data)
                        report_mismatch($sformatf("data %0d, expected %0d",
                                                  rsp.data, want.data));
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp.status, want.status));
                    if (rsp.count !== want.count)
                        report_mismatch($sformatf("count %0d, expected %0d",
                                                  rsp.count, want.count));
                    if (rsp.is_empty !== want.is_empty)
                        report_mismatch($sformatf("is_empty %0b, expected %0b",
                                                  rsp.is_empty, want.is_empty));
                end
            end
            if (req_valid && !req_stall)
            begin
                apply_list_op(req, want);
                expected_rsp.insert(expected_rsp.size(), want);
            end
            pending = expected_rsp.size();
        end
    end

    initial
    begin
        wait (final_check);
        foreach (expected_rsp[i])
            report_mismatch($sformatf("expected response never came (count %0d)",
                                      expected_rsp[i].count));
    end

endmodule

@@ tb/indexed_vector_store_tb.sv @@
`timescale 1ns / 1ps
// testbench top for the indexed vector store: clock, reset, request and response
// drivers, and the verdict; depends on ivs_pkg, ivs_checker and the block itself

module indexed_vector_store_tb;

    import ivs_pkg::*;

    localparam int ITEM_TOTAL  = 1450;
    localparam int CALM_ITEMS  = 150;
    localparam int HOLD_CYCLES = 150;

    typedef enum int {
        GROW,
        SHRINK,
        MIXED,
        NOISE
    } mix_t;

    logic       clk;
    logic       rst_n;
    req_t       req;
    logic       req_valid;
    logic       req_stall;
    rsp_t       rsp;
    logic       rsp_valid;
    logic       rsp_stall;
    logic       final_check;
    int         errors;
    int         pending;

    int         sent;
    int         gap_pct;
    int         hold_pct;
    logic       calm;
    logic       hold_rsp;
    logic [6:0] seen_count;

    indexed_vector_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

    ivs_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .rsp         (rsp),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .final_check (final_check),
        .errors      (errors),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // last observed size steers positions toward the interesting range
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_count <= '0;
        else if (rsp_valid && !rsp_stall)
            seen_count <= rsp.count;
    end

    // response side: short stall bursts, plus long hold-offs on request
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                rsp_stall <= 1'b0;
                hold_rsp = 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < hold_pct)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    task automatic send_op(input logic [2:0] f, input logic [6:0] pos, input logic [31:0] v);
        @(negedge clk);
        req.func     <= f;
        req.position <= pos;
        req.value    <= v;
        req_valid    <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        sent++;
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clk);
        end
    endtask

    function automatic logic [2:0] pick_func(input mix_t m);
        int r;
        r = $urandom_range(0, 99);
        case (m)
            GROW:
                return (r < 45) ? OP_APPEND : (r < 75) ? OP_INSERT :
                       (r < 85) ? OP_READ : (r < 93) ? OP_WRITE : OP_REMOVE;
            SHRINK:
                return (r < 55) ? OP_REMOVE : (r < 70) ? OP_READ :
                       (r < 80) ? OP_WRITE : (r < 90) ? OP_INSERT : OP_APPEND;
            default:
                return (r < 20) ? OP_READ : (r < 40) ? OP_WRITE :
                       (r < 60) ? OP_INSERT : (r < 80) ? OP_REMOVE : OP_APPEND;
        endcase
    endfunction

    function automatic logic [6:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 7'($urandom_range(0, 127));
        if (r < 18)
            return seen_count;
        return 7'($urandom_range(0, seen_count));
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return 32'h8000_0000;
        if (r < 8)
            return 32'h7FFF_FFFF;
        return $urandom;
    endfunction

    initial
    begin
        mix_t mode;
        int   phase;
        int   len;
        int   guard;
        int   pct_choice [3];

        pct_choice  = '{0, 10, 35};
        rst_n       = 1'b0;
        req         = '0;
        req_valid   = 1'b0;
        final_check = 1'b0;
        calm        = 1'b0;
        hold_rsp    = 1'b0;
        gap_pct     = 10;
        hold_pct    = 10;
        sent        = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty-store errors, boundaries, extremes and unused codes
        send_op(OP_READ,   7'd0,   32'h0);
        send_op(OP_REMOVE, 7'd0,   32'h0);
        send_op(OP_WRITE,  7'd0,   32'h1234);
        send_op(OP_INSERT, 7'd1,   32'h1);
        send_op(OP_INSERT, 7'd0,   32'h7FFF_FFFF);
        send_op(OP_APPEND, 7'd0,   32'h8000_0000);
        send_op(OP_INSERT, 7'd2,   32'h0);
        send_op(OP_INSERT, 7'd1,   32'hFFFF_FFFF);
        for (int i = 0; i < 4; i++)
            send_op(OP_READ, 7'(i), 32'h0);
        send_op(OP_READ,   7'd4,   32'h0);
        send_op(OP_READ,   7'd127, 32'h0);
        send_op(OP_WRITE,  7'd3,   32'h5555_5555);
        send_op(OP_WRITE,  7'd127, 32'hAAAA_AAAA);
        send_op(OP_REMOVE, 7'd1,   32'h0);
        send_op(OP_REMOVE, 7'd2,   32'h0);
        send_op(3'd5,      7'd127, 32'hAAAA_AAAA);
        send_op(3'd6,      7'd0,   32'h5555_5555);
        send_op(3'd7,      7'd64,  32'hFFFF_FFFF);
        send_op(OP_REMOVE, 7'd0,   32'h0);
        send_op(OP_REMOVE, 7'd0,   32'h0);
        send_op(OP_APPEND, 7'd127, 32'h1234_5678);

        // random phases of growing, shrinking, mixed and noisy traffic
        phase = 0;
        while (sent < ITEM_TOTAL)
        begin
            mode = (phase == 0) ? GROW : mix_t'($urandom_range(0, 3));
            len  = $urandom_range(20, 90);
            calm = (sent >= ITEM_TOTAL - CALM_ITEMS);
            gap_pct  = calm ? 0 : pct_choice[$urandom_range(0, 2)];
            hold_pct = calm ? 0 : pct_choice[$urandom_range(0, 2)];
            // long receiver hold-off while requests keep coming
            if (phase == 2 || phase == 9)
                hold_rsp = 1'b1;
            for (int i = 0; i < len && sent < ITEM_TOTAL; i++)
            begin
                if (mode == NOISE)
                    send_op(3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)), $urandom);
                else
                    send_op(pick_func(mode), pick_position(), pick_value());
            end
            // sender pause until the block has drained
            if (phase % 4 == 3)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                wait (pending == 0);
            end
            phase++;
        end

        @(negedge clk);
        req_valid <= 1'b0;
        for (guard = 0; guard < 20000 && pending != 0; guard++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        final_check = 1'b1;
        @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
